@@ rtl/core/fmlu_pkg.sv @@
// Shared types and constants of the FIFO mutex lock unit.
package fmlu_pkg;

  localparam int Threads = 16;
  localparam int TidW    = 4;
  localparam int AddrW   = $clog2(Threads);
  localparam int CntW    = $clog2(Threads + 1);

  localparam logic FuncLock   = 1'b0;
  localparam logic FuncUnlock = 1'b1;

  typedef enum logic [2:0] {
    StGranted  = 3'd0,
    StQueued   = 3'd1,
    StAlready  = 3'd2,
    StReleased = 3'd3,
    StHandoff  = 3'd4,
    StNotOwner = 3'd5
  } status_e;

  typedef enum logic {
    FsmIdle = 1'b0,
    FsmExec = 1'b1
  } fsm_e;

  typedef struct packed {
    logic            push;
    logic            pop;
    logic [TidW-1:0] push_tid;
  } q_cmd_t;

  typedef struct packed {
    logic [CntW-1:0] count;
    logic            empty;
    logic            full;
    logic [TidW-1:0] head_tid;
  } q_stat_t;

endpackage

@@ rtl/core/fifo_mutex_lock_unit.sv @@
// Top level of the FIFO mutex lock unit: request decode, lock state, result beat.
//
// Usage: a request beat (func_i, thread_id_i) is taken at a rising edge with
// start high and busy low. func_i low asks to lock, high asks to unlock.
// Busy is high for the one cycle in which the request is decided; the result
// beat (status_o, woken_thread_o, locked_now_o, owner_now_o) is shown with
// valid_o high for exactly one cycle, the cycle after busy. The receiver
// takes it at the edge ending that cycle and cannot stall it.
// The accepting edge registers the request and enters exec; the exec decision
// is registered into the result beat. No new request is taken while busy; the
// wait queue memory's head entry is read in the idle cycle ahead of each request.
// A new request may be started in the same cycle its predecessor's result
// is shown.
// Reset (rst_ni low, asynchronous) unlocks the mutex, empties the wait
// queue and clears the waiter map; no clearing pass is needed, queue
// entries are only used after they have been written.
module fifo_mutex_lock_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic                      func_i,
  input  logic [fmlu_pkg::TidW-1:0] thread_id_i,
  output logic                      valid_o,
  output logic [2:0]                status_o,
  output logic [fmlu_pkg::TidW-1:0] woken_thread_o,
  output logic                      locked_now_o,
  output logic [fmlu_pkg::TidW-1:0] owner_now_o
);

  fmlu_pkg::fsm_e    state_q, state_d;
  fmlu_pkg::q_cmd_t  q_cmd;
  fmlu_pkg::q_stat_t q_stat;

  logic                         req_func_q;
  logic [fmlu_pkg::TidW-1:0]    req_tid_q;
  logic                         lock_q, lock_d;
  logic [fmlu_pkg::TidW-1:0]    owner_q, owner_d;
  logic [fmlu_pkg::Threads-1:0] wmap_q, wmap_d;

  fmlu_pkg::status_e         status_n, status_q;
  logic [fmlu_pkg::TidW-1:0] woken_n, woken_q;
  logic                      valid_q, locked_out_q;
  logic [fmlu_pkg::TidW-1:0] owner_out_q;
  logic                      accept;

  assign accept = start && !busy;
  assign busy   = (state_q == fmlu_pkg::FsmExec);

  fmlu_wait_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (q_cmd),
    .stat_o (q_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fmlu_pkg::FsmIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fmlu_pkg::FsmIdle: if (accept) state_d = fmlu_pkg::FsmExec;
      fmlu_pkg::FsmExec: state_d = fmlu_pkg::FsmIdle;
      default:           state_d = fmlu_pkg::FsmIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_func_q <= func_i;
      req_tid_q  <= thread_id_i;
    end
  end

  // Request decision, active only in the exec cycle.
  always_comb begin
    lock_d          = lock_q;
    owner_d         = owner_q;
    wmap_d          = wmap_q;
    q_cmd.push      = 1'b0;
    q_cmd.pop       = 1'b0;
    q_cmd.push_tid  = req_tid_q;
    status_n        = fmlu_pkg::StNotOwner;
    woken_n         = '0;
    if (state_q == fmlu_pkg::FsmExec) begin
      if (fmlu_pkg::CntW'(req_tid_q) >= fmlu_pkg::CntW'(fmlu_pkg::Threads)) begin
        status_n = fmlu_pkg::StNotOwner;
      end else if (req_func_q == fmlu_pkg::FuncLock) begin
        if (!lock_q || owner_q == req_tid_q) begin
          lock_d   = 1'b1;
          owner_d  = req_tid_q;
          status_n = fmlu_pkg::StGranted;
        end else if (wmap_q[req_tid_q] || q_stat.full) begin
          status_n = fmlu_pkg::StAlready;
        end else begin
          q_cmd.push        = 1'b1;
          wmap_d[req_tid_q] = 1'b1;
          status_n          = fmlu_pkg::StQueued;
        end
      end else begin
        if (!lock_q || owner_q != req_tid_q) begin
          status_n = fmlu_pkg::StNotOwner;
        end else if (!q_stat.empty) begin
          q_cmd.pop = 1'b1;
          if (fmlu_pkg::CntW'(q_stat.head_tid) < fmlu_pkg::CntW'(fmlu_pkg::Threads)) begin
            wmap_d[q_stat.head_tid] = 1'b0;
          end
          owner_d  = q_stat.head_tid;
          woken_n  = q_stat.head_tid;
          status_n = fmlu_pkg::StHandoff;
        end else begin
          lock_d   = 1'b0;
          owner_d  = '0;
          status_n = fmlu_pkg::StReleased;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_q  <= 1'b0;
      owner_q <= '0;
      wmap_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      lock_q  <= lock_d;
      owner_q <= owner_d;
      wmap_q  <= wmap_d;
      valid_q <= (state_q == fmlu_pkg::FsmExec);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == fmlu_pkg::FsmExec) begin
      status_q     <= status_n;
      woken_q      <= woken_n;
      locked_out_q <= lock_d;
      owner_out_q  <= lock_d ? owner_d : '0;
    end
  end

  assign valid_o        = valid_q;
  assign status_o       = status_q;
  assign woken_thread_o = woken_q;
  assign locked_now_o   = locked_out_q;
  assign owner_now_o    = owner_out_q;

`ifndef SYNTHESIS
  a_exec_then_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (valid_o && !busy))
    else $error("result beat did not follow the exec cycle");

  a_accept_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not enter exec");

  a_handoff_locked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o == fmlu_pkg::StHandoff) |->
      (locked_now_o && owner_now_o == woken_thread_o))
    else $error("hand-off left mutex in wrong state");

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_stat.count <= fmlu_pkg::CntW'(fmlu_pkg::Threads))
      && (q_stat.empty == (wmap_q == '0)))
    else $error("wait queue count disagrees with waiter map");
`endif

endmodule

@@ rtl/core/fmlu_wait_queue.sv @@
// Wait queue of thread ids: synchronous memory plus head, tail and count.
module fmlu_wait_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fmlu_pkg::q_cmd_t  cmd_i,
  output fmlu_pkg::q_stat_t stat_o
);

  logic [fmlu_pkg::TidW-1:0]  mem [fmlu_pkg::Threads];
  logic [fmlu_pkg::TidW-1:0]  rd_q;
  logic [fmlu_pkg::AddrW-1:0] head_q, head_d;
  logic [fmlu_pkg::AddrW-1:0] tail_q, tail_d;
  logic [fmlu_pkg::CntW-1:0]  count_q, count_d;

  function automatic logic [fmlu_pkg::AddrW-1:0] next_slot(
    input logic [fmlu_pkg::AddrW-1:0] p
  );
    return (p == fmlu_pkg::AddrW'(fmlu_pkg::Threads - 1)) ? '0 : p + 1'b1;
  endfunction

  // Head entry is read every cycle; the control only pops after an idle
  // cycle, so the registered data always reflects the latest head and writes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[tail_q] <= cmd_i.push_tid;
    end
    rd_q <= mem[head_q];
  end

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (cmd_i.push) begin
      tail_d  = next_slot(tail_q);
      count_d = count_q + 1'b1;
    end
    if (cmd_i.pop) begin
      head_d  = next_slot(head_q);
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  assign stat_o.count    = count_q;
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.full     = (count_q >= fmlu_pkg::CntW'(fmlu_pkg::Threads));
  assign stat_o.head_tid = rd_q;

endmodule
